### hw/rtl/radar_ray_line_generator_unit_assert.svh
`ifndef RADAR_RAY_LINE_GENERATOR_UNIT_ASSERT_SVH
`define RADAR_RAY_LINE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRLG_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRLG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/rrlg_pkg.sv
package rrlg_pkg;

  localparam int unsigned AngleW = 9;
  localparam int unsigned RangeW = 10;
  localparam int unsigned XW     = 10;
  localparam int unsigned YW     = 9;
  localparam int unsigned ColorW = 16;
  localparam int unsigned SinW   = 17;
  localparam int unsigned DistW  = 8;
  localparam int unsigned ProdW  = 26;
  localparam int unsigned CoordW = 12;

  localparam logic [AngleW-1:0] AngleEntries = 9'd360;
  localparam logic [AngleW-1:0] FullTurn     = 9'd360;
  localparam logic [AngleW-1:0] QuarterTurn  = 9'd90;
  localparam logic [AngleW-1:0] HalfTurn     = 9'd180;
  localparam logic [AngleW-1:0] ThreeQuarter = 9'd270;

  localparam logic [DistW-1:0] RimRadius = 8'd180;
  localparam logic [DistW-1:0] NearLimit = 8'd4;

  localparam logic signed [CoordW-1:0] CenterX = 12'sd160;
  localparam logic signed [CoordW-1:0] CenterY = 12'sd220;

  localparam logic [ColorW-1:0] Green565 = 16'h07E0;
  localparam logic [ColorW-1:0] Red565   = 16'hF800;

  typedef enum logic [1:0] {
    CfgHalve  = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [AngleW-1:0] sweep_angle;
    logic [RangeW-1:0] range_cm;
  } ray_t;

  typedef struct packed {
    logic [XW-1:0]     start_x;
    logic [YW-1:0]     start_y;
    logic [XW-1:0]     end_x;
    logic [YW-1:0]     end_y;
    logic [ColorW-1:0] line_color;
    logic              last_line;
  } line_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [XW-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic          halve;
    logic [XW-1:0] width;
    logic [YW-1:0] height;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [SinW-1:0] cos_q15;
    logic signed [SinW-1:0] sin_q15;
    logic [DistW-1:0]       clamp_dist;
    logic                   short_range;
  } work_t;

  // sin(k degrees) in Q1.15, k = 0..90
  function automatic logic [15:0] quarter_sine(logic [6:0] k);
    logic [15:0] v;
    unique case (k)
      7'd0: v = 16'd0;          7'd1: v = 16'd572;        7'd2: v = 16'd1144;
      7'd3: v = 16'd1715;       7'd4: v = 16'd2286;       7'd5: v = 16'd2856;
      7'd6: v = 16'd3425;       7'd7: v = 16'd3993;       7'd8: v = 16'd4560;
      7'd9: v = 16'd5126;       7'd10: v = 16'd5690;      7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;      7'd13: v = 16'd7371;      7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;      7'd16: v = 16'd9032;      7'd17: v = 16'd9580;
      7'd18: v = 16'd10126;     7'd19: v = 16'd10668;     7'd20: v = 16'd11207;
      7'd21: v = 16'd11743;     7'd22: v = 16'd12275;     7'd23: v = 16'd12803;
      7'd24: v = 16'd13328;     7'd25: v = 16'd13848;     7'd26: v = 16'd14365;
      7'd27: v = 16'd14876;     7'd28: v = 16'd15384;     7'd29: v = 16'd15886;
      7'd30: v = 16'd16384;     7'd31: v = 16'd16877;     7'd32: v = 16'd17364;
      7'd33: v = 16'd17847;     7'd34: v = 16'd18324;     7'd35: v = 16'd18795;
      7'd36: v = 16'd19261;     7'd37: v = 16'd19720;     7'd38: v = 16'd20174;
      7'd39: v = 16'd20622;     7'd40: v = 16'd21063;     7'd41: v = 16'd21498;
      7'd42: v = 16'd21926;     7'd43: v = 16'd22348;     7'd44: v = 16'd22763;
      7'd45: v = 16'd23170;     7'd46: v = 16'd23571;     7'd47: v = 16'd23965;
      7'd48: v = 16'd24351;     7'd49: v = 16'd24730;     7'd50: v = 16'd25102;
      7'd51: v = 16'd25466;     7'd52: v = 16'd25822;     7'd53: v = 16'd26170;
      7'd54: v = 16'd26510;     7'd55: v = 16'd26842;     7'd56: v = 16'd27166;
      7'd57: v = 16'd27482;     7'd58: v = 16'd27789;     7'd59: v = 16'd28088;
      7'd60: v = 16'd28378;     7'd61: v = 16'd28660;     7'd62: v = 16'd28932;
      7'd63: v = 16'd29197;     7'd64: v = 16'd29452;     7'd65: v = 16'd29698;
      7'd66: v = 16'd29935;     7'd67: v = 16'd30163;     7'd68: v = 16'd30382;
      7'd69: v = 16'd30592;     7'd70: v = 16'd30792;     7'd71: v = 16'd30983;
      7'd72: v = 16'd31164;     7'd73: v = 16'd31336;     7'd74: v = 16'd31499;
      7'd75: v = 16'd31651;     7'd76: v = 16'd31795;     7'd77: v = 16'd31928;
      7'd78: v = 16'd32052;     7'd79: v = 16'd32166;     7'd80: v = 16'd32270;
      7'd81: v = 16'd32365;     7'd82: v = 16'd32449;     7'd83: v = 16'd32524;
      7'd84: v = 16'd32588;     7'd85: v = 16'd32643;     7'd86: v = 16'd32688;
      7'd87: v = 16'd32723;     7'd88: v = 16'd32748;     7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Fold a degree value (0..359) onto the quarter table
  function automatic logic signed [SinW-1:0] sine_q15(logic [AngleW-1:0] deg);
    logic [AngleW-1:0] idx;
    logic              neg;
    logic [15:0]       mag;
    priority if (deg <= QuarterTurn) begin
      idx = deg;
      neg = 1'b0;
    end else if (deg <= HalfTurn) begin
      idx = HalfTurn - deg;
      neg = 1'b0;
    end else if (deg <= ThreeQuarter) begin
      idx = deg - HalfTurn;
      neg = 1'b1;
    end else begin
      idx = FullTurn - deg;
      neg = 1'b1;
    end
    mag = quarter_sine(idx[6:0]);
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Drop 15 fraction bits, rounding toward zero
  function automatic logic signed [CoordW-1:0] trunc_q15(logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] b;
    b = p + (p[ProdW-1] ? 26'sd32767 : 26'sd0);
    return CoordW'(b >>> 15);
  endfunction

  // Optional halving, then clamp to 0..size-1 (size 0 acts as 1)
  function automatic logic [XW-1:0] fit_axis(logic signed [CoordW-1:0] v, logic halve,
                                             logic [XW-1:0] size);
    logic signed [CoordW-1:0] h;
    logic [XW-1:0]            lim;
    logic [XW-1:0]            r;
    h   = halve ? (v >>> 1) : v;
    lim = (size == '0) ? '0 : size - 10'd1;
    priority if (h < 0) begin
      r = '0;
    end else if (h > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = h[XW-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/rrlg_chan_if.sv
interface rrlg_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/radar_ray_line_generator_unit.sv
// Radar ray line generator. Each request on ray_in (sweep angle in degrees, distance in cm)
// yields a green line command from the center (160,220) to the object and, when the
// distance clamped to 4..180 is below 180, a red line from the object to the rim at
// radius 180; last_line marks the final command of a request. Endpoints are optionally
// halved and clamped to the screen size held in the configuration registers, written
// through cfg_wr (always ready; write only while no request is in flight). Each line is one
// transfer on line_out, so while line_out is ready, requests are accepted every cycle for
// full-range rays, and a request that draws both lines holds back the next one until its red
// line is sent; that one line per cycle output port sets the rate. The first line passes
// through the queue, product stage, hold stage and output register in that order. QUEUE_DEPTH
// sets the number of classified requests buffered between front and back.
module radar_ray_line_generator_unit import rrlg_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rrlg_chan_if.sink    ray_in,
  rrlg_chan_if.source  line_out,
  rrlg_chan_if.sink    cfg_wr
);

  cfg_regs_t cfg_q;
  logic      work_valid, work_ready, deq_valid, deq_ready;
  work_t     work, deq_work;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.halve  <= 1'b0;
      cfg_q.width  <= 10'd320;
      cfg_q.height <= 9'd240;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.data.index)
        CfgHalve:  cfg_q.halve  <= cfg_wr.data.value[0];
        CfgWidth:  cfg_q.width  <= cfg_wr.data.value;
        CfgHeight: cfg_q.height <= cfg_wr.data.value[YW-1:0];
        default:   cfg_q        <= cfg_q;
      endcase
    end
  end

  rrlg_front u_front (
    .ray_in       (ray_in),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  rrlg_queue #(
    .DEPTH (QUEUE_DEPTH),
    .T     (work_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (work_valid),
    .push_ready_o (work_ready),
    .push_data_i  (work),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_data_o   (deq_work)
  );

  rrlg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_valid_i (deq_valid),
    .work_ready_o (deq_ready),
    .work_i       (deq_work),
    .line_out     (line_out)
  );

endmodule

### hw/rtl/rrlg_front.sv
module rrlg_front import rrlg_pkg::*; (
  rrlg_chan_if.sink    ray_in,
  output logic         work_valid_o,
  input  logic         work_ready_i,
  output work_t        work_o
);

  logic [AngleW-1:0] angle_mod;
  logic [AngleW-1:0] angle_sat;
  logic [AngleW-1:0] cos_deg;
  logic [DistW-1:0]  clamp_dist;

  always_comb begin
    angle_mod = (ray_in.data.sweep_angle >= FullTurn) ?
                ray_in.data.sweep_angle - FullTurn : ray_in.data.sweep_angle;
    angle_sat = (angle_mod >= AngleEntries) ? AngleEntries - 9'd1 : angle_mod;
    // cos(a) = sin(a + 90), wrapped into one turn
    cos_deg   = (angle_sat >= ThreeQuarter) ? angle_sat - ThreeQuarter
                                            : angle_sat + QuarterTurn;
    priority if (ray_in.data.range_cm < RangeW'(NearLimit)) begin
      clamp_dist = NearLimit;
    end else if (ray_in.data.range_cm > RangeW'(RimRadius)) begin
      clamp_dist = RimRadius;
    end else begin
      clamp_dist = ray_in.data.range_cm[DistW-1:0];
    end
  end

  assign work_o.cos_q15     = sine_q15(cos_deg);
  assign work_o.sin_q15     = sine_q15(angle_sat);
  assign work_o.clamp_dist  = clamp_dist;
  assign work_o.short_range = (clamp_dist < RimRadius);

  assign work_valid_o = ray_in.valid;
  assign ray_in.ready = work_ready_i;

endmodule

### hw/rtl/rrlg_queue.sv
module rrlg_queue #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  T     push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output T     pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

  T                slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/rrlg_back.sv
`include "radar_ray_line_generator_unit_assert.svh"

module rrlg_back import rrlg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_regs_t    cfg_i,
  input  logic         work_valid_i,
  output logic         work_ready_o,
  input  work_t        work_i,
  rrlg_chan_if.source  line_out
);

  // product stage
  logic                    prod_valid_q;
  logic signed [ProdW-1:0] pcd_q, psd_q, pcr_q, psr_q;
  logic                    pshort_q;
  logic signed [ProdW-1:0] c_ext, s_ext, d_ext, r_ext;

  // hold stage: object and rim points of one request
  logic                     hold_valid_q;
  logic                     phase_q;
  logic                     hshort_q;
  logic signed [CoordW-1:0] ox_q, oy_q, rx_q, ry_q;

  // output register
  logic  out_valid_q;
  line_t out_q, out_d;

  logic out_ready, emit_fire, line_last, hold_ready, hold_load, prod_ready, prod_load;
  logic signed [CoordW-1:0] sx, sy, ex, ey;

  assign out_ready  = !out_valid_q || line_out.ready;
  assign emit_fire  = hold_valid_q && out_ready;
  assign line_last  = phase_q || !hshort_q;
  assign hold_ready = !hold_valid_q || (emit_fire && line_last);
  assign hold_load  = prod_valid_q && hold_ready;
  assign prod_ready = !prod_valid_q || hold_ready;
  assign prod_load  = work_valid_i && prod_ready;

  assign work_ready_o   = prod_ready;
  assign line_out.valid = out_valid_q;
  assign line_out.data  = out_q;

  assign c_ext = ProdW'(work_i.cos_q15);
  assign s_ext = ProdW'(work_i.sin_q15);
  assign d_ext = $signed({{(ProdW-DistW){1'b0}}, work_i.clamp_dist});
  assign r_ext = $signed({{(ProdW-DistW){1'b0}}, RimRadius});

  always_comb begin
    sx = phase_q ? ox_q : CenterX;
    sy = phase_q ? oy_q : CenterY;
    ex = phase_q ? rx_q : ox_q;
    ey = phase_q ? ry_q : oy_q;
    out_d.start_x    = fit_axis(sx, cfg_i.halve, cfg_i.width);
    out_d.start_y    = YW'(fit_axis(sy, cfg_i.halve, {1'b0, cfg_i.height}));
    out_d.end_x      = fit_axis(ex, cfg_i.halve, cfg_i.width);
    out_d.end_y      = YW'(fit_axis(ey, cfg_i.halve, {1'b0, cfg_i.height}));
    out_d.line_color = phase_q ? Red565 : Green565;
    out_d.last_line  = line_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      hold_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= work_valid_i;
      end
      if (hold_ready) begin
        hold_valid_q <= prod_valid_q;
      end
      // advance to the red line, drop back after the final line
      if (hold_load) begin
        phase_q <= 1'b0;
      end else if (emit_fire) begin
        phase_q <= !line_last;
      end
      if (out_ready) begin
        out_valid_q <= hold_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      pcd_q    <= c_ext * d_ext;
      psd_q    <= s_ext * d_ext;
      pcr_q    <= c_ext * r_ext;
      psr_q    <= s_ext * r_ext;
      pshort_q <= work_i.short_range;
    end
    if (hold_load) begin
      ox_q     <= CenterX - trunc_q15(pcd_q);
      oy_q     <= CenterY - trunc_q15(psd_q);
      rx_q     <= CenterX - trunc_q15(pcr_q);
      ry_q     <= CenterY - trunc_q15(psr_q);
      hshort_q <= pshort_q;
    end
    if (emit_fire) begin
      out_q <= out_d;
    end
  end

  `RRLG_ASSERT_IMPL(a_red_only_when_short, emit_fire && phase_q, hshort_q,
                    "red line emitted for a full-range request")
  `RRLG_ASSERT_IMPL(a_hold_not_overwritten, hold_load && hold_valid_q,
                    emit_fire && line_last, "hold stage overwritten before its last line")
  `RRLG_ASSERT_NEXT(a_phase_clears, emit_fire && line_last, !phase_q,
                    "phase not cleared after the last line")
  `RRLG_ASSERT_NEXT(a_red_follows_green, emit_fire && !line_last,
                    hold_valid_q && phase_q, "red line not pending after green line")

endmodule

### tb/sv/radar_ray_line_generator_unit_test.sv
module radar_ray_line_generator_unit_test;
  import rrlg_pkg::*;

  class line_scoreboard;
    line_t       pending_lines[$];
    bit          halve;
    int unsigned width;
    int unsigned height;
    int          errors;
    int          sine_q15[360];

    function new();
      real pi;
      pi = 3.14159265358979;
      halve  = 1'b0;
      width  = 320;
      height = 240;
      errors = 0;
      for (int k = 0; k < 360; k++) begin
        sine_q15[k] = $rtoi($floor($sin(k * pi / 180.0) * 32768.0 + 0.5));
      end
    endfunction

    function void set_reg(cfg_index_e idx, logic [XW-1:0] value);
      case (idx)
        CfgHalve:  halve  = value[0];
        CfgWidth:  width  = value;
        CfgHeight: height = value[YW-1:0];
        default: ;
      endcase
    endfunction

    // Halve (toward zero), then clamp to 0..size-1; size 0 behaves as 1
    function int unsigned fit(int v, int unsigned size);
      int lim;
      if (halve) v = v / 2;
      lim = (size == 0) ? 0 : int'(size) - 1;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v;
    endfunction

    function line_t make_line(int x0, int y0, int x1, int y1, logic [ColorW-1:0] color,
                              bit last);
      line_t l;
      l.start_x    = XW'(fit(x0, width));
      l.start_y    = YW'(fit(y0, height));
      l.end_x      = XW'(fit(x1, width));
      l.end_y      = YW'(fit(y1, height));
      l.line_color = color;
      l.last_line  = last;
      return l;
    endfunction

    function void note_ray(ray_t r);
      int angle, clamp_dist, c, s, ox, oy, rx, ry;
      angle      = int'(r.sweep_angle) % 360;
      clamp_dist = r.range_cm;
      if (clamp_dist < 4) clamp_dist = 4;
      if (clamp_dist > 180) clamp_dist = 180;
      c  = sine_q15[(angle + 90) % 360];
      s  = sine_q15[angle];
      // int division truncates toward zero, as the products require
      ox = 160 - (c * clamp_dist) / 32768;
      oy = 220 - (s * clamp_dist) / 32768;
      rx = 160 - (c * 180) / 32768;
      ry = 220 - (s * 180) / 32768;
      if (clamp_dist < 180) begin
        pending_lines.push_back(make_line(160, 220, ox, oy, 16'h07E0, 1'b0));
        pending_lines.push_back(make_line(ox, oy, rx, ry, 16'hF800, 1'b1));
      end else begin
        pending_lines.push_back(make_line(160, 220, ox, oy, 16'h07E0, 1'b1));
      end
    endfunction

    function void check_line(line_t got);
      line_t want;
      if (pending_lines.size() == 0) begin
        $error("line command with none pending: %p", got);
        errors++;
        return;
      end
      want = pending_lines.pop_front();
      if (got.start_x !== want.start_x) begin
        $error("start_x expected %0d got %0d", want.start_x, got.start_x);
        errors++;
      end
      if (got.start_y !== want.start_y) begin
        $error("start_y expected %0d got %0d", want.start_y, got.start_y);
        errors++;
      end
      if (got.end_x !== want.end_x) begin
        $error("end_x expected %0d got %0d", want.end_x, got.end_x);
        errors++;
      end
      if (got.end_y !== want.end_y) begin
        $error("end_y expected %0d got %0d", want.end_y, got.end_y);
        errors++;
      end
      if (got.line_color !== want.line_color) begin
        $error("line_color expected %h got %h", want.line_color, got.line_color);
        errors++;
      end
      if (got.last_line !== want.last_line) begin
        $error("last_line expected %0d got %0d", want.last_line, got.last_line);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  rrlg_chan_if #(.T(ray_t))     ray_ch ();
  rrlg_chan_if #(.T(line_t))    line_ch ();
  rrlg_chan_if #(.T(cfg_req_t)) cfg_ch ();

  line_scoreboard sb = new();

  radar_ray_line_generator_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .ray_in  (ray_ch),
    .line_out(line_ch),
    .cfg_wr  (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // Observe every handshake at the edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_reg(cfg_index_e'(cfg_ch.data.index), cfg_ch.data.value);
      end
      if (ray_ch.valid && ray_ch.ready) sb.note_ray(ray_ch.data);
      if (line_ch.valid && line_ch.ready) sb.check_line(line_ch.data);
    end
    line_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Leave valid high on return; the next request or the caller drops it
  task automatic send_ray(logic [AngleW-1:0] angle, logic [RangeW-1:0] range_cm);
    ray_t r;
    r.sweep_angle = angle;
    r.range_cm    = range_cm;
    while ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.data  <= r;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_ray();
    logic [AngleW-1:0] angle;
    logic [RangeW-1:0] range_cm;
    angle = ($urandom_range(9) == 0) ? AngleW'($urandom_range(511, 360))
                                     : AngleW'($urandom_range(359, 0));
    case ($urandom_range(3))
      0: range_cm = RangeW'($urandom_range(4, 0));
      1: range_cm = RangeW'($urandom_range(179, 5));
      2: range_cm = RangeW'($urandom_range(1023, 180));
      default: range_cm = RangeW'($urandom_range(1023, 0));
    endcase
    send_ray(angle, range_cm);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [XW-1:0] value);
    cfg_req_t req;
    req.index = idx;
    req.value = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= req;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Upper bits beyond each register's width are junk and must be ignored
  task automatic apply_settings(bit halve, logic [XW-1:0] width, logic [YW-1:0] height);
    write_reg(CfgHalve, {9'($urandom_range(511)), halve});
    write_reg(CfgWidth, width);
    write_reg(CfgHeight, {1'($urandom_range(1)), height});
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, let the last accepted request be noted, then wait until no lines are pending
  task automatic drain();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_lines.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit          halve_set[7]  = '{0, 1, 0, 1, 0, 1, 0};
    int unsigned width_set[7]  = '{320, 640, 640, 160, 1, 0, 1023};
    int unsigned height_set[7] = '{240, 480, 480, 120, 1, 0, 511};
    int unsigned dir_angle[20] = '{0, 0, 0, 90, 90, 180, 180, 270, 270, 359,
                                   360, 511, 45, 1, 135, 225, 315, 89, 91, 256};
    int unsigned dir_range[20] = '{0, 180, 1023, 3, 180, 4, 5, 179, 181, 1023,
                                   100, 0, 160, 170, 90, 180, 2, 179, 512, 1023};
    int          mode;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n         = 1'b0;
    ray_ch.valid  <= 1'b0;
    ray_ch.data   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays under the reset settings
    for (int i = 0; i < 20; i++) send_ray(AngleW'(dir_angle[i]), RangeW'(dir_range[i]));
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        apply_settings(1'($urandom_range(1)), XW'($urandom_range(1023)),
                       YW'($urandom_range(511)));
      end else begin
        apply_settings(halve_set[p], XW'(width_set[p]), YW'(height_set[p]));
      end
      mode = p * 3 / 7;
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 62 : 0;
      recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 37 : 0;
      for (int i = 0; i < 200; i++) send_random_ray();
      drain();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_lines.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
